// ===== src/dcws_pkg.sv =====
// dcws_pkg: types and constants shared by the channel word serializer
// covers command codes, the queue entry format and the chip register map
// no dependencies
package dcws_pkg;

	typedef enum logic [1:0] {
		CMD_FREQ     = 2'd0,
		CMD_AMP      = 2'd1,
		CMD_PHASE    = 2'd2,
		CMD_FREQ_ALL = 2'd3
	} cmd_t;

	// one decoded command waiting for the byte sequencer
	typedef struct packed {
		cmd_t        cmd;
		logic [1:0]  ch;
		logic [31:0] word;   // register data, left aligned, msb first
	} entry_t;

	// register addresses
	localparam logic [7:0] ADDR_CSR = 8'h00;
	localparam logic [7:0] ADDR_FTW = 8'h04;
	localparam logic [7:0] ADDR_POW = 8'h05;
	localparam logic [7:0] ADDR_ACR = 8'h06;

	localparam logic [7:0] CH_SEL_BASE = 8'h10;
	localparam logic [7:0] AMP_ENABLE  = 8'h10;

	// byte positions inside one write
	localparam logic [2:0] BYTE_CSR  = 3'd0;
	localparam logic [2:0] BYTE_SEL  = 3'd1;
	localparam logic [2:0] BYTE_ADDR = 3'd2;
	localparam logic [2:0] BYTE_DATA = 3'd3;

	// index of the final byte of a write per command
	localparam logic [2:0] LAST_FREQ  = 3'd6;
	localparam logic [2:0] LAST_AMP   = 3'd5;
	localparam logic [2:0] LAST_PHASE = 3'd4;

	// configuration register indexes
	localparam logic REG_TUNING_SCALE = 1'b0;
	localparam logic REG_PHASE_SCALE  = 1'b1;

	localparam int QUEUE_DEPTH = 2;

endpackage

// ===== src/dcws_front.sv =====
// dcws_front: accepts commands, drops absent channels and forms register data
// two stages: operand capture with scaling multiply, then tuning word add
// depends on dcws_pkg
module dcws_front
	import dcws_pkg::*;
#(
	parameter int NUM_CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  command,
	input  logic [1:0]  channel,
	input  logic [28:0] value,
	input  logic [35:0] tuning_scale,
	input  logic [22:0] phase_scale,
	output logic        push,
	output entry_t      push_entry,
	input  logic        queue_full
);

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [1:0]  ch_s1;
	logic [28:0] v_s1;

	logic        valid_s2;
	cmd_t        cmd_s2;
	logic [1:0]  ch_s2;
	logic [9:0]  amp_s2;
	logic [60:0] prod_s2;
	logic [31:0] hi_prod_s2;

	logic        accept;
	logic        present;
	logic        move_s1;
	logic [31:0] mul_b;
	logic [60:0] prod;
	logic [32:0] hi_prod;
	logic [31:0] tw;

	assign push      = valid_s2 && !queue_full;
	assign move_s1   = valid_s1 && (!valid_s2 || push);
	assign cmd_stall = valid_s1 && !move_s1;
	assign accept    = cmd_valid && !cmd_stall;

	// all-channel writes always go out, single-channel ones need a fitted channel
	assign present = (cmd_t'(command) == CMD_FREQ_ALL) || (32'(channel) < NUM_CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= present;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_t'(command);
			ch_s1  <= channel;
			v_s1   <= value;
		end
	end

	// shared low multiplier: fractional scale for frequency, phase scale for phase
	assign mul_b   = (cmd_s1 == CMD_PHASE) ? {9'b0, phase_scale} : tuning_scale[31:0];
	assign prod    = 61'(v_s1) * 61'(mul_b);
	assign hi_prod = 33'(v_s1) * 33'(tuning_scale[35:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1) begin
			valid_s2 <= 1'b1;
		end else if (push) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			cmd_s2     <= cmd_s1;
			ch_s2      <= ch_s1;
			amp_s2     <= v_s1[9:0];
			prod_s2    <= prod;
			hi_prod_s2 <= hi_prod[31:0];
		end
	end

	assign tw = hi_prod_s2 + {3'b0, prod_s2[60:32]};

	always_comb begin
		push_entry.cmd = cmd_s2;
		push_entry.ch  = ch_s2;
		unique case (cmd_s2)
			CMD_AMP:   push_entry.word = {8'h00, AMP_ENABLE | {6'b0, amp_s2[9:8]},
				amp_s2[7:0], 8'h00};
			CMD_PHASE: push_entry.word = {prod_s2[31:16], 16'h0000};
			default:   push_entry.word = tw;
		endcase
	end

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1)
		else $error("front stalls with an empty first stage");
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !push |=> valid_s2 && $stable(prod_s2))
		else $error("second stage lost an item waiting for queue space");
`endif

endmodule

// ===== src/dcws_queue.sv =====
// dcws_queue: short queue of decoded commands between front and back
// depends on dcws_pkg
module dcws_queue
	import dcws_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");
`endif

endmodule

// ===== src/dcws_back.sv =====
// dcws_back: walks each queued command through its spi bytes, one per cycle while byte_stall is low
// channel select frame then register frame, repeated per channel for all-channel writes
// depends on dcws_pkg
module dcws_back
	import dcws_pkg::*;
#(
	parameter int NUM_CHANNELS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  entry_t     head,
	output logic       pop,
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] spi_byte,
	output logic       frame_start,
	output logic       frame_end,
	output logic       pulse_update,
	output logic       last
);

	localparam logic [1:0] LAST_CH = 2'(NUM_CHANNELS - 1);

	logic [2:0] b_idx_q;
	logic [1:0] w_idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       fs_q;
	logic       fe_q;
	logic       upd_q;
	logic       last_q;

	logic       adv;
	logic [2:0] last_idx;
	logic [1:0] wr_ch;
	logic       last_write;
	logic [1:0] data_k;
	logic [7:0] nxt_byte;
	logic [7:0] data_byte;
	logic [7:0] reg_addr;
	logic       nxt_fs;
	logic       nxt_fe;
	logic       nxt_last;
	logic       end_of_write;

	assign adv = head_valid && (!out_valid_q || !byte_stall);

	always_comb begin
		unique case (head.cmd)
			CMD_AMP: begin
				last_idx = LAST_AMP;
				reg_addr = ADDR_ACR;
			end
			CMD_PHASE: begin
				last_idx = LAST_PHASE;
				reg_addr = ADDR_POW;
			end
			default: begin
				last_idx = LAST_FREQ;
				reg_addr = ADDR_FTW;
			end
		endcase
	end

	assign wr_ch      = (head.cmd == CMD_FREQ_ALL) ? w_idx_q : head.ch;
	assign last_write = (head.cmd != CMD_FREQ_ALL) || (w_idx_q == LAST_CH);
	assign data_k     = 2'(b_idx_q - BYTE_DATA);

	always_comb begin
		case (data_k)
			2'd0:    data_byte = head.word[31:24];
			2'd1:    data_byte = head.word[23:16];
			2'd2:    data_byte = head.word[15:8];
			default: data_byte = head.word[7:0];
		endcase
	end

	always_comb begin
		case (b_idx_q)
			BYTE_CSR:  nxt_byte = ADDR_CSR;
			BYTE_SEL:  nxt_byte = CH_SEL_BASE << wr_ch;
			BYTE_ADDR: nxt_byte = reg_addr;
			default:   nxt_byte = data_byte;
		endcase
	end

	assign end_of_write = (b_idx_q == last_idx);
	assign nxt_fs       = (b_idx_q == BYTE_CSR) || (b_idx_q == BYTE_ADDR);
	assign nxt_fe       = (b_idx_q == BYTE_SEL) || end_of_write;
	assign nxt_last     = end_of_write && last_write;
	assign pop          = adv && nxt_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_idx_q     <= BYTE_CSR;
			w_idx_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				if (end_of_write) begin
					b_idx_q <= BYTE_CSR;
					w_idx_q <= last_write ? 2'd0 : w_idx_q + 2'd1;
				end else begin
					b_idx_q <= b_idx_q + 3'd1;
				end
			end else if (!byte_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= nxt_byte;
			fs_q   <= nxt_fs;
			fe_q   <= nxt_fe;
			upd_q  <= nxt_fe && (head.cmd != CMD_PHASE);
			last_q <= nxt_last;
		end
	end

	assign byte_valid   = out_valid_q;
	assign spi_byte     = byte_q;
	assign frame_start  = fs_q;
	assign frame_end    = fe_q;
	assign pulse_update = upd_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_byte_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		b_idx_q <= LAST_FREQ)
		else $error("byte index ran past the longest write");
	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (last_q || upd_q) |-> fe_q)
		else $error("last or update flag away from a frame end");
`endif

endmodule

// ===== src/dds_channel_word_serializer_core.sv =====
// dds channel word serializer: spi byte frames for a four-channel dds
// top level, holds the scale registers and joins front, queue and back
// depends on dcws_pkg, dcws_front, dcws_queue, dcws_back
//
// usage:
//  command channel (cmd_valid/cmd_stall) takes command, channel and value.
//  byte channel (byte_valid/byte_stall) gives one spi byte per transfer with
//  frame_start, frame_end, pulse_update and last flags.
//  cfg_we writes tuning_scale (index 0) or phase_scale (index 1); write only
//  while no command is in flight.
// timing:
//  the first byte passes the first front stage (loaded on the transfer), the
//  second stage, the queue and the byte register. the byte sequencer then
//  gives one byte per cycle while byte_stall is low: a phase command has 5
//  bytes, amplitude 6, frequency 7, all-channel frequency 7 * NUM_CHANNELS;
//  that sequencer sets the rate.
//  commands to an absent channel give no bytes; the front drops them.
//  the front takes commands while bytes wait, until queue and both stages fill.
// reset: clears all valid state and loads the default scales (500 MHz
//  system clock). a stalled byte holds until taken; the stall reaches the
//  command channel only once the queue and front stages are full.
module dds_channel_word_serializer_core
	import dcws_pkg::*;
#(
	parameter int NUM_CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [35:0] cfg_data,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  command,
	input  logic [1:0]  channel,
	input  logic [28:0] value,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  spi_byte,
	output logic        frame_start,
	output logic        frame_end,
	output logic        pulse_update,
	output logic        last
);

	logic [35:0] tuning_scale_q;
	logic [22:0] phase_scale_q;

	logic   push;
	entry_t push_entry;
	logic   queue_full;
	logic   pop;
	logic   head_valid;
	entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuning_scale_q <= 36'd36893488147;
			phase_scale_q  <= 23'd2982616;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TUNING_SCALE: tuning_scale_q <= cfg_data;
				REG_PHASE_SCALE:  phase_scale_q  <= cfg_data[22:0];
				default:          ;
			endcase
		end
	end

	dcws_front #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.command      (command),
		.channel      (channel),
		.value        (value),
		.tuning_scale (tuning_scale_q),
		.phase_scale  (phase_scale_q),
		.push         (push),
		.push_entry   (push_entry),
		.queue_full   (queue_full)
	);

	dcws_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	dcws_back #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.spi_byte     (spi_byte),
		.frame_start  (frame_start),
		.frame_end    (frame_end),
		.pulse_update (pulse_update),
		.last         (last)
	);

endmodule
